FILE: sv/grid_path_one_wall_break_unit_defines.svh
// Assertion macros shared by the grid path search block.
`ifndef GRID_PATH_ONE_WALL_BREAK_UNIT_DEFINES_SVH
`define GRID_PATH_ONE_WALL_BREAK_UNIT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define GPOWB_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be seen outside reset.
`define GPOWB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/gpowb_pkg.sv
// Package with the types, codes and constants of the grid path search block.
`timescale 1ns / 1ps
package gpowb_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int DIST_W = 14;
  localparam logic [DIST_W-1:0] UNREACHED = 14'h3FFF;

  localparam logic [1:0] KIND_OPEN = 2'd0;
  localparam logic [1:0] KIND_WALL = 2'd1;

  typedef enum logic [2:0] {
    REG_ROW_COUNT,
    REG_COL_COUNT,
    REG_START_ROW,
    REG_START_COL,
    REG_GOAL_ROW,
    REG_GOAL_COL
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_LEFT,
    DIR_DOWN,
    DIR_RIGHT
  } dir_t;

  typedef enum logic [1:0] {
    RD_POP,
    RD_NBR,
    RD_JMP
  } rd_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_CLEAR,
    S_SEED,
    S_LEVEL,
    S_POP,
    S_POPW,
    S_STALE,
    S_DIR,
    S_NRD,
    S_NKIND,
    S_R1RD,
    S_R1WR,
    S_JCHK,
    S_WRD,
    S_WKIND,
    S_R2RD,
    S_R2WR,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] cell_kind;
    logic       last_cell;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] distance;
  } result_t;

  typedef struct packed {
    logic    load;
    logic    init;
    logic    clr_wr;
    logic    seed;
    logic    pop;
    logic    dir_first;
    logic    dir_next;
    logic    addr_nbr;
    logic    addr_jmp;
    logic    kind_latch;
    logic    rlx_wr;
    logic    tgt_jmp;
    logic    hit;
    logic    next_level;
    logic    finish;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic out_range;
    logic scan_last;
    logic all_empty;
    logic k_lt_len;
    logic d_last;
    logic stale;
    logic at_goal;
    logic nbr_ok;
    logic jmp_ok;
    logic kind_open;
    logic nkind_wall;
    logic dir_last;
  } sts_t;

endpackage

FILE: sv/gpowb_dp.sv
// Datapath of the grid path search: cell store, distance store, bucket queues and counters.
`timescale 1ns / 1ps
module gpowb_dp #(
  parameter int MAX_ROWS = gpowb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gpowb_pkg::MAX_COLS_DEF,
  localparam int RCW = $clog2(MAX_ROWS + 1),
  localparam int CCW = $clog2(MAX_COLS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  gpowb_pkg::item_t    item,
  input  logic [RCW-1:0]      rows,
  input  logic [CCW-1:0]      cols,
  input  logic [5:0]          start_row,
  input  logic [5:0]          start_col,
  input  logic [5:0]          goal_row,
  input  logic [5:0]          goal_col,
  input  gpowb_pkg::cmd_t     cmd,
  output gpowb_pkg::sts_t     sts,
  output gpowb_pkg::result_t  result
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(CELLS);
  localparam int LIW = $clog2(CELLS + 1);
  localparam int SW = 1 + RW + CW;
  localparam int SDEPTH = 2 ** SW;
  localparam int STATES = 2 * CELLS;
  localparam int QIW = $clog2(STATES);
  localparam int QLW = $clog2(STATES + 1);
  localparam int QDEPTH = 2 ** (QIW + 2);
  localparam int DW = gpowb_pkg::DIST_W;
  localparam int PW = RW + CCW;

  function automatic logic [1:0] mod3_add(input logic [1:0] b, input logic [1:0] inc);
    logic [2:0] s;
    s = {1'b0, b} + {1'b0, inc};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  logic [LIW-1:0] load_idx;
  logic [1:0]     cell_mem [CELLS];
  logic [AW-1:0]  cell_addr;
  logic [1:0]     kind_q;
  logic [1:0]     nkind;

  logic [DW-1:0]  dist_mem [SDEPTH];
  logic [DW-1:0]  dist_q;
  logic [SW-1:0]  q_mem [QDEPTH];
  logic [SW-1:0]  q_q;

  logic [QLW-1:0] len0, len1, len2;
  logic [QLW-1:0] k;
  logic [DW-1:0]  d;
  logic [1:0]     cb;
  logic [SW-1:0]  scan;
  logic           cl;
  logic [RW-1:0]  cr;
  logic [CW-1:0]  cc;
  gpowb_pkg::dir_t dir;
  logic           found_q;
  logic [DW-1:0]  res_dist;

  logic signed [2:0]    dr, dc, dr2, dc2;
  logic signed [RW+1:0] nr, wr;
  logic signed [CW+1:0] nc, wc;
  logic [RW-1:0]  nr_u, wr_u, sel_r;
  logic [CW-1:0]  nc_u, wc_u, sel_c;
  logic [PW-1:0]  prod;
  logic [SW-1:0]  rd_addr, start_state;
  logic [DW:0]    nd;
  logic           improve;
  logic [1:0]     pb;
  logic [QLW-1:0] len_cb, plen;
  logic           push_en;
  logic [1:0]     push_b;
  logic [QLW-1:0] push_idx;
  logic [SW-1:0]  push_data;
  logic           dist_we;
  logic [SW-1:0]  dist_waddr;
  logic [DW-1:0]  dist_wdata;
  logic           load_ok;

  assign load_ok = load_idx < LIW'(CELLS);
  assign start_state = {1'b0, RW'(start_row), CW'(start_col)};

  always_comb begin
    dr = 3'sd0;
    dc = 3'sd0;
    case (dir)
      gpowb_pkg::DIR_UP:    dr = -3'sd1;
      gpowb_pkg::DIR_LEFT:  dc = -3'sd1;
      gpowb_pkg::DIR_DOWN:  dr = 3'sd1;
      gpowb_pkg::DIR_RIGHT: dc = 3'sd1;
      default:              dr = 3'sd0;
    endcase
    dr2 = dr <<< 1;
    dc2 = dc <<< 1;
    nr = $signed({2'b00, cr}) + (RW + 2)'(dr);
    nc = $signed({2'b00, cc}) + (CW + 2)'(dc);
    wr = $signed({2'b00, cr}) + (RW + 2)'(dr2);
    wc = $signed({2'b00, cc}) + (CW + 2)'(dc2);
  end

  assign nr_u = nr[RW-1:0];
  assign nc_u = nc[CW-1:0];
  assign wr_u = wr[RW-1:0];
  assign wc_u = wc[CW-1:0];

  assign sel_r = cmd.addr_jmp ? wr_u : nr_u;
  assign sel_c = cmd.addr_jmp ? wc_u : nc_u;
  assign prod = sel_r * cols + PW'(sel_c);

  always_comb begin
    case (cmd.rd_sel)
      gpowb_pkg::RD_NBR: rd_addr = {cl, nr_u, nc_u};
      gpowb_pkg::RD_JMP: rd_addr = {1'b1, wr_u, wc_u};
      default:           rd_addr = q_q;
    endcase
  end

  assign nd = {1'b0, d} + (cmd.tgt_jmp ? (DW + 1)'(2) : (DW + 1)'(1));
  assign improve = (nd < {1'b0, gpowb_pkg::UNREACHED}) && ({1'b0, dist_q} > nd);
  assign pb = mod3_add(cb, cmd.tgt_jmp ? 2'd2 : 2'd1);

  always_comb begin
    case (cb)
      2'd0:    len_cb = len0;
      2'd1:    len_cb = len1;
      default: len_cb = len2;
    endcase
    case (pb)
      2'd0:    plen = len0;
      2'd1:    plen = len1;
      default: plen = len2;
    endcase
  end

  assign push_en = cmd.seed || (cmd.rlx_wr && improve && plen < QLW'(STATES));
  assign push_b = cmd.seed ? 2'd0 : pb;
  assign push_idx = cmd.seed ? '0 : plen;
  assign push_data = cmd.seed ? start_state : rd_addr;

  always_comb begin
    dist_we = 1'b0;
    dist_waddr = scan;
    dist_wdata = gpowb_pkg::UNREACHED;
    if (cmd.clr_wr) begin
      dist_we = 1'b1;
    end else if (cmd.seed) begin
      dist_we = 1'b1;
      dist_waddr = start_state;
      dist_wdata = '0;
    end else if (cmd.rlx_wr && improve) begin
      dist_we = 1'b1;
      dist_waddr = rd_addr;
      dist_wdata = nd[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_idx <= '0;
    end else if (cmd.finish) begin
      load_idx <= '0;
    end else if (cmd.load && load_ok) begin
      load_idx <= load_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      cell_mem[load_idx[AW-1:0]] <= item.cell_kind;
    end
    kind_q <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_q <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_mem[{push_b, push_idx[QIW-1:0]}] <= push_data;
    end
    q_q <= q_mem[{cb, k[QIW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      len0 <= '0;
      len1 <= '0;
      len2 <= '0;
    end else if (cmd.seed) begin
      len0 <= QLW'(1);
    end else begin
      if (cmd.next_level) begin
        case (cb)
          2'd0:    len0 <= '0;
          2'd1:    len1 <= '0;
          default: len2 <= '0;
        endcase
      end
      if (push_en) begin
        case (pb)
          2'd0:    len0 <= len0 + 1'b1;
          2'd1:    len1 <= len1 + 1'b1;
          default: len2 <= len2 + 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      scan <= '0;
      found_q <= 1'b0;
      res_dist <= '0;
    end else if (cmd.clr_wr) begin
      scan <= scan + 1'b1;
    end
    if (cmd.hit) begin
      found_q <= 1'b1;
      res_dist <= d;
    end
    if (cmd.seed) begin
      d <= '0;
      cb <= 2'd0;
      k <= '0;
    end else if (cmd.next_level) begin
      d <= d + 1'b1;
      cb <= mod3_add(cb, 2'd1);
      k <= '0;
    end else if (cmd.pop) begin
      k <= k + 1'b1;
    end
    if (cmd.pop) begin
      {cl, cr, cc} <= q_q;
    end
    if (cmd.dir_first) begin
      dir <= gpowb_pkg::DIR_UP;
    end else if (cmd.dir_next) begin
      dir <= gpowb_pkg::dir_t'(2'(dir + 2'd1));
    end
    if (cmd.addr_nbr || cmd.addr_jmp) begin
      cell_addr <= prod[AW-1:0];
    end
    if (cmd.kind_latch) begin
      nkind <= kind_q;
    end
  end

  always_comb begin
    sts.out_range = (int'(start_row) >= int'(rows)) || (int'(start_col) >= int'(cols)) ||
                    (int'(goal_row) >= int'(rows)) || (int'(goal_col) >= int'(cols));
    sts.scan_last = (scan == {SW{1'b1}});
    sts.all_empty = (len0 == '0) && (len1 == '0) && (len2 == '0);
    sts.k_lt_len = k < len_cb;
    sts.d_last = (d == gpowb_pkg::UNREACHED - 1'b1);
    sts.stale = (dist_q != d);
    sts.at_goal = (int'(cr) == int'(goal_row)) && (int'(cc) == int'(goal_col));
    sts.nbr_ok = (nr >= 0) && (int'(nr) < int'(rows)) && (nc >= 0) && (int'(nc) < int'(cols));
    sts.jmp_ok = !cl && (wr >= 0) && (int'(wr) < int'(rows)) &&
                 (wc >= 0) && (int'(wc) < int'(cols));
    sts.kind_open = (kind_q == gpowb_pkg::KIND_OPEN);
    sts.nkind_wall = (nkind == gpowb_pkg::KIND_WALL);
    sts.dir_last = (dir == gpowb_pkg::DIR_RIGHT);
  end

  assign result.found = found_q;
  assign result.distance = res_dist;

endmodule

FILE: sv/gpowb_ctrl.sv
// Controller state machine that sequences loading and the two-layer bucket search.
`timescale 1ns / 1ps
`include "grid_path_one_wall_break_unit_defines.svh"
module gpowb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            last_cell,
  input  gpowb_pkg::sts_t sts,
  output gpowb_pkg::cmd_t cmd,
  output logic            busy,
  output logic            done
);

  gpowb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpowb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gpowb_pkg::S_IDLE:  if (start && last_cell) state_next = gpowb_pkg::S_CHECK;
      gpowb_pkg::S_CHECK: state_next = sts.out_range ? gpowb_pkg::S_DONE : gpowb_pkg::S_CLEAR;
      gpowb_pkg::S_CLEAR: if (sts.scan_last) state_next = gpowb_pkg::S_SEED;
      gpowb_pkg::S_SEED:  state_next = gpowb_pkg::S_LEVEL;
      gpowb_pkg::S_LEVEL: begin
        if (sts.all_empty) begin
          state_next = gpowb_pkg::S_DONE;
        end else if (sts.k_lt_len) begin
          state_next = gpowb_pkg::S_POP;
        end else if (sts.d_last) begin
          state_next = gpowb_pkg::S_DONE;
        end
      end
      gpowb_pkg::S_POP:   state_next = gpowb_pkg::S_POPW;
      gpowb_pkg::S_POPW:  state_next = gpowb_pkg::S_STALE;
      gpowb_pkg::S_STALE: begin
        if (sts.stale) begin
          state_next = gpowb_pkg::S_LEVEL;
        end else if (sts.at_goal) begin
          state_next = gpowb_pkg::S_DONE;
        end else begin
          state_next = gpowb_pkg::S_DIR;
        end
      end
      gpowb_pkg::S_DIR:   state_next = sts.nbr_ok ? gpowb_pkg::S_NRD : gpowb_pkg::S_NEXT;
      gpowb_pkg::S_NRD:   state_next = gpowb_pkg::S_NKIND;
      gpowb_pkg::S_NKIND: state_next = sts.kind_open ? gpowb_pkg::S_R1RD : gpowb_pkg::S_JCHK;
      gpowb_pkg::S_R1RD:  state_next = gpowb_pkg::S_R1WR;
      gpowb_pkg::S_R1WR:  state_next = gpowb_pkg::S_JCHK;
      gpowb_pkg::S_JCHK: begin
        state_next = (sts.jmp_ok && sts.nkind_wall) ? gpowb_pkg::S_WRD : gpowb_pkg::S_NEXT;
      end
      gpowb_pkg::S_WRD:   state_next = gpowb_pkg::S_WKIND;
      gpowb_pkg::S_WKIND: state_next = sts.kind_open ? gpowb_pkg::S_R2RD : gpowb_pkg::S_NEXT;
      gpowb_pkg::S_R2RD:  state_next = gpowb_pkg::S_R2WR;
      gpowb_pkg::S_R2WR:  state_next = gpowb_pkg::S_NEXT;
      gpowb_pkg::S_NEXT:  state_next = sts.dir_last ? gpowb_pkg::S_LEVEL : gpowb_pkg::S_DIR;
      gpowb_pkg::S_DONE:  state_next = gpowb_pkg::S_IDLE;
      default:            state_next = gpowb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = gpowb_pkg::RD_POP;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      gpowb_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      gpowb_pkg::S_CHECK: cmd.init = 1'b1;
      gpowb_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
      gpowb_pkg::S_SEED:  cmd.seed = 1'b1;
      gpowb_pkg::S_LEVEL: begin
        cmd.next_level = !sts.all_empty && !sts.k_lt_len && !sts.d_last;
      end
      gpowb_pkg::S_POP:   cmd.rd_sel = gpowb_pkg::RD_POP;
      gpowb_pkg::S_POPW:  cmd.pop = 1'b1;
      gpowb_pkg::S_STALE: begin
        cmd.hit = !sts.stale && sts.at_goal;
        cmd.dir_first = !sts.stale && !sts.at_goal;
      end
      gpowb_pkg::S_DIR:   cmd.addr_nbr = sts.nbr_ok;
      gpowb_pkg::S_NRD:   cmd.rd_sel = gpowb_pkg::RD_POP;
      gpowb_pkg::S_NKIND: cmd.kind_latch = 1'b1;
      gpowb_pkg::S_R1RD:  cmd.rd_sel = gpowb_pkg::RD_NBR;
      gpowb_pkg::S_R1WR: begin
        cmd.rd_sel = gpowb_pkg::RD_NBR;
        cmd.rlx_wr = 1'b1;
      end
      gpowb_pkg::S_JCHK:  cmd.addr_jmp = sts.jmp_ok && sts.nkind_wall;
      gpowb_pkg::S_WRD:   cmd.rd_sel = gpowb_pkg::RD_POP;
      gpowb_pkg::S_WKIND: cmd.rd_sel = gpowb_pkg::RD_POP;
      gpowb_pkg::S_R2RD: begin
        cmd.rd_sel = gpowb_pkg::RD_JMP;
        cmd.tgt_jmp = 1'b1;
      end
      gpowb_pkg::S_R2WR: begin
        cmd.rd_sel = gpowb_pkg::RD_JMP;
        cmd.tgt_jmp = 1'b1;
        cmd.rlx_wr = 1'b1;
      end
      gpowb_pkg::S_NEXT:  cmd.dir_next = !sts.dir_last;
      gpowb_pkg::S_DONE: begin
        done = 1'b1;
        cmd.finish = 1'b1;
      end
      default:            busy = 1'b1;
    endcase
  end

  `GPOWB_ASSERT_HOLDS(a_done_then_idle, done |=> !busy, "Block still busy after its result word.")
  `GPOWB_ASSERT_HOLDS(a_last_starts, (start && !busy && last_cell) |=> busy, "Last cell did not start a search.")
  `GPOWB_ASSERT_HOLDS(a_stale_after_pop, (state == gpowb_pkg::S_STALE) |-> $past(state == gpowb_pkg::S_POPW), "Distance check without a preceding pop.")
  `GPOWB_ASSERT_NEVER(a_relax_and_seed, cmd.rlx_wr && (cmd.seed || cmd.clr_wr), "Relaxation overlaps seeding or clearing.")

endmodule

FILE: sv/grid_path_one_wall_break_unit.sv
// Top level of the grid shortest path search with at most one wall break.
// Grid cells are given one word at a time on item while busy is low; a word is
// taken at a clock edge with start high and busy low.
// Cells are stored in row-major order; the word with last_cell set also starts
// the search, and busy stays high until the search is over.
// The search first clears the distance store, one entry a cycle. It then visits
// entries of three distance buckets and, for each entry taken from a bucket,
// checks its four neighbours in turn, the steps being set by the single port
// of the cell store and of the distance store.
// done is high for exactly one cycle, with the result word valid on result; busy
// falls in the following cycle. The receiver cannot hold the result off.
// Registers are written on the cfg channel (cfg_valid and cfg_ready) only while
// the block is idle; unknown indexes are ignored. Reset returns the block to idle
// with an empty load position and the register reset values.
`timescale 1ns / 1ps
module grid_path_one_wall_break_unit #(
  parameter int MAX_ROWS = gpowb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gpowb_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  gpowb_pkg::item_t   item,
  output logic               done,
  output gpowb_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  logic [6:0] row_count, col_count;
  logic [5:0] start_row, start_col, goal_row, goal_col;
  logic [RCW-1:0] rows;
  logic [CCW-1:0] cols;
  gpowb_pkg::cmd_t cmd;
  gpowb_pkg::sts_t sts;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 7'd1;
      col_count <= 7'd1;
      start_row <= '0;
      start_col <= '0;
      goal_row <= '0;
      goal_col <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpowb_pkg::REG_ROW_COUNT: row_count <= cfg_data;
        gpowb_pkg::REG_COL_COUNT: col_count <= cfg_data;
        gpowb_pkg::REG_START_ROW: start_row <= cfg_data[5:0];
        gpowb_pkg::REG_START_COL: start_col <= cfg_data[5:0];
        gpowb_pkg::REG_GOAL_ROW:  goal_row <= cfg_data[5:0];
        gpowb_pkg::REG_GOAL_COL:  goal_col <= cfg_data[5:0];
        default:                  row_count <= row_count;
      endcase
    end
  end

  always_comb begin
    if (row_count == '0) begin
      rows = RCW'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = RCW'(row_count);
    end
    if (col_count == '0) begin
      cols = CCW'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      cols = CCW'(MAX_COLS);
    end else begin
      cols = CCW'(col_count);
    end
  end

  gpowb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_cell (item.last_cell),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  gpowb_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .rows      (rows),
    .cols      (cols),
    .start_row (start_row),
    .start_col (start_col),
    .goal_row  (goal_row),
    .goal_col  (goal_col),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule
